>>> rtl/skstk_pkg.sv
package skstk_pkg;

	// Default sizes of the block
	localparam int unsigned NUM_STACKS_DEF = 4;
	localparam int unsigned CAPACITY_DEF   = 64;
	localparam int unsigned DATA_WIDTH_DEF = 32;

	// Fixed widths of the channel words
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned ID_W    = 2;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_POP  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Index width for a table of n entries, never below one bit
	function automatic int unsigned idx_w(input int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

>>> rtl/skstk_if.sv
// Request channel: one word per push or pop
interface skstk_req_if import skstk_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      req_type;
	logic [ID_W-1:0]           stack_id;
	logic signed [VALUE_W-1:0] push_value;

	modport source (output valid, req_type, stack_id, push_value, input ready);
	modport sink   (input valid, req_type, stack_id, push_value, output ready);
endinterface

// Response channel: one word per request
interface skstk_rsp_if import skstk_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] pop_value;
	logic [1:0]                status;

	modport source (output valid, pop_value, status, input ready);
	modport sink   (input valid, pop_value, status, output ready);
endinterface

>>> rtl/shared_buffer_k_stacks.sv
// Several LIFO stacks share one buffer of CAPACITY slots; free slots are
// chained in a free list and each stack chains its slots from the top down.
// Every request word gives exactly one response word: status OK, FULL (push
// with no free slot) or EMPTY (pop of an empty stack); a refused request
// changes nothing and returns pop_value zero. Requests are handled one at a
// time: a push or a refused pop reads the stack top and slot link in
// parallel, then a push writes them back; a successful pop takes an extra
// S_SLOT step because the slot address comes from the stack top read. A
// finished response sits in an output register; the block holds its last
// step while that register is still full. Stack ids at or above NUM_STACKS
// wrap modulo NUM_STACKS. No clearing pass is needed after reset.
module shared_buffer_k_stacks import skstk_pkg::*; #(
	parameter int unsigned NUM_STACKS = NUM_STACKS_DEF,
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	skstk_req_if.sink    req,
	skstk_rsp_if.source  rsp
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned SW = idx_w(NUM_STACKS);
	localparam logic [LW-1:0] NULL_LINK = LW'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_HEAD,
		S_SLOT
	} state_t;

	state_t                  state_q;
	req_type_t               op_q;
	logic [SW-1:0]           sid_q;
	logic [DATA_WIDTH-1:0]   val_q;
	logic [LW-1:0]           free_head_q;
	logic                    rsp_valid_q;
	logic [VALUE_W-1:0]      rsp_value_q;
	status_t                 rsp_status_q;

	logic [6:0]              sid_mod;
	logic [SW-1:0]           sid_next;
	logic                    accept;
	logic                    out_free;
	logic                    head_null;
	logic                    free_null;
	logic                    finish_push;
	logic                    finish_empty;
	logic                    finish_pop;
	logic                    go_slot;

	logic                    head_wr_en;
	logic [LW-1:0]           head_wr_data;
	logic [LW-1:0]           head_rd;

	logic                    slot_rd_en;
	logic [AW-1:0]           slot_rd_addr;
	logic [DATA_WIDTH-1:0]   slot_data_rd;
	logic [LW-1:0]           slot_link_rd;
	logic [AW-1:0]           slot_wr_addr;
	logic [DATA_WIDTH-1:0]   slot_wr_data;
	logic [LW-1:0]           slot_wr_link;

	logic signed [DATA_WIDTH-1:0] pop_data_s;
	logic [VALUE_W-1:0]           pop_word;

	// Stack id wraps modulo NUM_STACKS (two-bit id, at most three subtracts)
	always_comb begin
		sid_mod = 7'(req.stack_id);
		for (int i = 0; i < 3; i++) begin
			if (sid_mod >= 7'(NUM_STACKS)) begin
				sid_mod = sid_mod - 7'(NUM_STACKS);
			end
		end
	end
	assign sid_next = SW'(sid_mod);

	// Handshake and step decode
	assign req.ready    = (state_q == S_IDLE);
	assign accept       = req.valid && req.ready;
	assign out_free     = !rsp_valid_q || rsp.ready;
	assign head_null    = (head_rd >= NULL_LINK);
	assign free_null    = (free_head_q >= NULL_LINK);
	assign finish_push  = (state_q == S_HEAD) && (op_q == REQ_PUSH) && out_free;
	assign finish_empty = (state_q == S_HEAD) && (op_q == REQ_POP) && head_null && out_free;
	assign go_slot      = (state_q == S_HEAD) && (op_q == REQ_POP) && !head_null;
	assign finish_pop   = (state_q == S_SLOT) && out_free;

	// Write-back: push puts the free head slot on top, linked to the old top,
	// pop hands the top slot to the free list
	assign head_wr_en   = (finish_push && !free_null) || finish_pop;
	assign head_wr_data = finish_pop ? slot_link_rd : free_head_q;

	assign slot_rd_en   = accept || go_slot;
	assign slot_rd_addr = go_slot ? head_rd[AW-1:0] : free_head_q[AW-1:0];
	assign slot_wr_addr = finish_pop ? head_rd[AW-1:0] : free_head_q[AW-1:0];
	assign slot_wr_data = finish_pop ? slot_data_rd : val_q;
	assign slot_wr_link = finish_pop ? free_head_q : head_rd;

	// Popped word: sign-extend from DATA_WIDTH, keep 32 bits
	assign pop_data_s = slot_data_rd;
	assign pop_word   = 32'(pop_data_s);

	skstk_head_mem #(
		.NUM_STACKS (NUM_STACKS),
		.CAPACITY   (CAPACITY)
	) u_head_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (sid_next),
		.rd_data (head_rd),
		.wr_en   (head_wr_en),
		.wr_addr (sid_q),
		.wr_data (head_wr_data)
	);

	skstk_slot_mem #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (slot_rd_en),
		.rd_addr (slot_rd_addr),
		.rd_data (slot_data_rd),
		.rd_link (slot_link_rd),
		.wr_en   (head_wr_en),
		.wr_addr (slot_wr_addr),
		.wr_data (slot_wr_data),
		.wr_link (slot_wr_link)
	);

	// Sequencer, free head and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= REQ_PUSH;
			sid_q        <= '0;
			val_q        <= '0;
			free_head_q  <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_value_q  <= '0;
			rsp_status_q <= STAT_OK;
		end else begin
			// Drain the response word unless a new one replaces it now
			if (rsp_valid_q && rsp.ready
					&& !finish_push && !finish_empty && !finish_pop) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= req_type_t'(req.req_type);
						sid_q   <= sid_next;
						val_q   <= DATA_WIDTH'($unsigned(req.push_value));
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (finish_push) begin
						if (!free_null) begin
							free_head_q <= slot_link_rd;
						end
						rsp_valid_q  <= 1'b1;
						rsp_value_q  <= '0;
						rsp_status_q <= free_null ? STAT_FULL : STAT_OK;
						state_q      <= S_IDLE;
					end else if (finish_empty) begin
						rsp_valid_q  <= 1'b1;
						rsp_value_q  <= '0;
						rsp_status_q <= STAT_EMPTY;
						state_q      <= S_IDLE;
					end else if (go_slot) begin
						state_q <= S_SLOT;
					end
				end
				S_SLOT: begin
					if (finish_pop) begin
						free_head_q  <= head_rd;
						rsp_valid_q  <= 1'b1;
						rsp_value_q  <= pop_word;
						rsp_status_q <= STAT_OK;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.pop_value = rsp_value_q;
	assign rsp.status    = rsp_status_q;

	// A push never links a slot while the free list is empty
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(head_wr_en && (op_q == REQ_PUSH)) |-> !free_null)
		else $error("push committed with empty free list");

	// Refused requests return a zero word
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (rsp_status_q != STAT_OK)) |-> (rsp_value_q == '0))
		else $error("refused request returned nonzero word");

	// A pop returns its slot to the head of the free list
	a_pop_frees_slot: assert property (@(posedge clk) disable iff (!arst_n)
		finish_pop |=> (free_head_q == $past(head_rd)))
		else $error("popped slot not placed on free list");

endmodule

>>> rtl/skstk_slot_mem.sv
// Slot memory: data word and link word per slot, one write and one read port.
// Slots at or above the fill mark were never written; their link reads as
// the next slot index, which is the free chain left by reset.
module skstk_slot_mem import skstk_pkg::*; #(
	parameter int unsigned CAPACITY   = CAPACITY_DEF,
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [$clog2(CAPACITY)-1:0]    rd_addr,
	output logic [DATA_WIDTH-1:0]          rd_data,
	output logic [$clog2(CAPACITY+1)-1:0]  rd_link,
	input  logic                           wr_en,
	input  logic [$clog2(CAPACITY)-1:0]    wr_addr,
	input  logic [DATA_WIDTH-1:0]          wr_data,
	input  logic [$clog2(CAPACITY+1)-1:0]  wr_link
);

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned WW = DATA_WIDTH + LW;

	logic [WW-1:0] mem [CAPACITY];
	logic [WW-1:0] rd_word_q;
	logic [AW-1:0] rd_addr_q;
	logic          rd_fresh_q;
	logic [LW-1:0] fill_q;

	// Memory array, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_data, wr_link};
		end
		if (rd_en) begin
			rd_word_q  <= mem[rd_addr];
			rd_addr_q  <= rd_addr;
			rd_fresh_q <= (LW'(rd_addr) >= fill_q);
		end
	end

	// Fill mark: slots are first touched in index order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr_en && (LW'(wr_addr) == fill_q)) begin
			fill_q <= fill_q + LW'(1);
		end
	end

	assign rd_data = rd_word_q[WW-1:LW];
	assign rd_link = rd_fresh_q ? (LW'(rd_addr_q) + LW'(1)) : rd_word_q[LW-1:0];

	// Writes never skip past an untouched slot
	a_wr_within_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (LW'(wr_addr) <= fill_q))
		else $error("slot write beyond fill mark");

endmodule

>>> rtl/skstk_head_mem.sv
// Stack top table: one entry per stack, registered read. Entries never
// written since reset read as the null link.
module skstk_head_mem import skstk_pkg::*; #(
	parameter int unsigned NUM_STACKS = NUM_STACKS_DEF,
	parameter int unsigned CAPACITY   = CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           rd_en,
	input  logic [idx_w(NUM_STACKS)-1:0]   rd_addr,
	output logic [$clog2(CAPACITY+1)-1:0]  rd_data,
	input  logic                           wr_en,
	input  logic [idx_w(NUM_STACKS)-1:0]   wr_addr,
	input  logic [$clog2(CAPACITY+1)-1:0]  wr_data
);

	localparam int unsigned LW = $clog2(CAPACITY + 1);

	logic [LW-1:0]         mem [NUM_STACKS];
	logic [NUM_STACKS-1:0] valid_q;
	logic [LW-1:0]         rd_data_q;

	// Array and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : LW'(CAPACITY);
		end
	end

	// Per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> tb/tb_shared_buffer_k_stacks.sv
`timescale 1ns / 100ps

module tb_shared_buffer_k_stacks;
	import skstk_pkg::*;

	localparam int unsigned NSTK   = NUM_STACKS_DEF;
	localparam int unsigned NSLOT  = CAPACITY_DEF;
	localparam int unsigned LINK_W = $clog2(NSLOT + 1);
	localparam int unsigned SLOT_W = $clog2(NSLOT);
	localparam int unsigned STK_W  = idx_w(NSTK);
	localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(NSLOT);

	// Where the receiver holds off for a long stretch, and for how long
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 250;
	// Random part size, and how many words at the end run without idling
	localparam int RAND_WORDS  = 1030;
	localparam int CALM_WORDS  = 150;

	typedef struct {
		req_type_t                 op;
		logic [ID_W-1:0]           sid;
		logic signed [VALUE_W-1:0] val;
		bit                        drain_first; // sender waits for all responses
		bit                        calm;        // no idling from here on
	} stack_req_t;

	typedef struct {
		logic signed [VALUE_W-1:0] pop_value;
		status_t                   status;
	} stack_rsp_t;

	logic clk;
	logic arst_n;

	skstk_req_if req_ch ();
	skstk_rsp_if rsp_ch ();

	shared_buffer_k_stacks i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Local copy of the shared buffer
	logic [VALUE_W-1:0] buf_data [NSLOT];
	logic [LINK_W-1:0]  buf_link [NSLOT];
	logic [LINK_W-1:0]  top_slot [NSTK];
	logic [LINK_W-1:0]  free_slot;

	stack_req_t pending_ops [$];
	stack_rsp_t expected_rsp [$];

	int  err_cnt    = 0;
	int  rsp_seen   = 0;
	bit  req_acc    = 1'b0;
	bit  calm_mode  = 1'b0;
	int  gap_left   = 0;
	int  stall_left = 0;
	int  hold_left  = 0;
	bit  hold_done  = 1'b0;

	task automatic clear_buffer_model();
		for (int i = 0; i < NSLOT; i++) begin
			buf_data[i] = '0;
			buf_link[i] = LINK_W'(i + 1);
		end
		for (int i = 0; i < NSTK; i++) begin
			top_slot[i] = NO_SLOT;
		end
		free_slot = '0;
	endtask

	// Apply one push or pop to the local buffer and give the response it causes
	function automatic stack_rsp_t apply_stack_op(input stack_req_t w);
		stack_rsp_t        r;
		logic [LINK_W-1:0] slot;
		logic [STK_W-1:0]  sid;
		r.pop_value = '0;
		r.status    = STAT_OK;
		sid         = STK_W'(int'(w.sid) % NSTK);
		if (w.op == REQ_PUSH) begin
			slot = free_slot;
			if (slot >= NO_SLOT) begin
				r.status = STAT_FULL;
			end else begin
				buf_data[slot[SLOT_W-1:0]] = w.val;
				free_slot                  = buf_link[slot[SLOT_W-1:0]];
				buf_link[slot[SLOT_W-1:0]] = top_slot[sid];
				top_slot[sid]              = slot;
			end
		end else begin
			slot = top_slot[sid];
			if (slot >= NO_SLOT) begin
				r.status = STAT_EMPTY;
			end else begin
				top_slot[sid]              = buf_link[slot[SLOT_W-1:0]];
				buf_link[slot[SLOT_W-1:0]] = free_slot;
				free_slot                  = slot;
				r.pop_value                = buf_data[slot[SLOT_W-1:0]];
			end
		end
		return r;
	endfunction

	task automatic add_op(input req_type_t op, input int sid, input logic [VALUE_W-1:0] v,
			input bit drain = 1'b0, input bit calm = 1'b0);
		stack_req_t w;
		w.op          = op;
		w.sid         = ID_W'(sid);
		w.val         = v;
		w.drain_first = drain;
		w.calm        = calm;
		pending_ops.insert(pending_ops.size(), w);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] v;
		case ($urandom_range(0, 11))
			0: begin
				v = 32'h8000_0000;
			end
			1: begin
				v = 32'h7FFF_FFFF;
			end
			2: begin
				v = '0;
			end
			3: begin
				v = '1;
			end
			default: begin
				v = $urandom;
			end
		endcase
		return v;
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		#4_000_000;
		$display("** shared_buffer_k_stacks: FAILED **");
		$finish;
	end

	// Sampling at the rising edge: predict accepted requests, check responses
	always @(posedge clk) begin
		stack_rsp_t exp_w;
		if (!arst_n) begin
			req_acc = 1'b0;
			clear_buffer_model();
		end else begin
			req_acc = req_ch.valid && req_ch.ready;
			if (req_acc) begin
				stack_req_t w;
				w.op  = req_type_t'(req_ch.req_type);
				w.sid = req_ch.stack_id;
				w.val = req_ch.push_value;
				expected_rsp.insert(expected_rsp.size(), apply_stack_op(w));
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsp_seen++;
				if (expected_rsp.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected response word pop_value=%h status=%0d",
						$time, rsp_ch.pop_value, rsp_ch.status);
				end else begin
					exp_w = expected_rsp.pop_front();
					if (rsp_ch.pop_value !== exp_w.pop_value) begin
						err_cnt++;
						$display("%0t: pop_value mismatch: expected %h, actual %h",
							$time, exp_w.pop_value, rsp_ch.pop_value);
					end
					if (rsp_ch.status !== exp_w.status) begin
						err_cnt++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, exp_w.status, rsp_ch.status);
					end
				end
			end
		end
	end

	// Request driver, fed from pending_ops
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid      <= 1'b0;
			req_ch.req_type   <= REQ_PUSH;
			req_ch.stack_id   <= '0;
			req_ch.push_value <= '0;
		end else if (req_ch.valid && !req_acc) begin
			// word still on offer
		end else if (gap_left > 0) begin
			gap_left--;
			req_ch.valid <= 1'b0;
		end else if (pending_ops.size() == 0) begin
			req_ch.valid <= 1'b0;
		end else if (pending_ops[0].drain_first && expected_rsp.size() != 0) begin
			req_ch.valid <= 1'b0;
		end else if (!calm_mode && !pending_ops[0].calm && $urandom_range(0, 5) == 0) begin
			gap_left = $urandom_range(0, 16);
			req_ch.valid <= 1'b0;
		end else begin
			stack_req_t w;
			w = pending_ops.pop_front();
			if (w.calm) begin
				calm_mode = 1'b1;
			end
			req_ch.valid      <= 1'b1;
			req_ch.req_type   <= w.op;
			req_ch.stack_id   <= w.sid;
			req_ch.push_value <= w.val;
		end
	end

	// Response receiver with random stalls and one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (!hold_done && rsp_seen >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!calm_mode && $urandom_range(0, 6) == 0) begin
				stall_left = $urandom_range(0, 16);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int n;
		int kind;
		int seg_len;
		int push_pct;
		int focus;
		int sid;
		req_type_t op;

		arst_n = 1'b0;

		// Directed: pops of empty stacks, extreme values, LIFO order
		for (int i = 0; i < NSTK; i++) begin
			add_op(REQ_POP, i, '0);
		end
		add_op(REQ_PUSH, 0, 32'h7FFF_FFFF);
		add_op(REQ_PUSH, 1, 32'h8000_0000);
		add_op(REQ_PUSH, 2, 32'h0000_0000);
		add_op(REQ_PUSH, 3, 32'hFFFF_FFFF);
		add_op(REQ_PUSH, 0, 32'h0000_0001);
		add_op(REQ_POP, 0, 32'hFFFF_FFFF);
		add_op(REQ_POP, 0, '0);
		add_op(REQ_POP, 0, '0);
		add_op(REQ_POP, 1, '0);
		add_op(REQ_POP, 2, '0);
		add_op(REQ_POP, 3, '0);
		add_op(REQ_POP, 3, '0);
		add_op(REQ_PUSH, 2, 32'h5555_5555);
		add_op(REQ_PUSH, 2, 32'hAAAA_AAAA);
		add_op(REQ_POP, 2, '0);
		add_op(REQ_POP, 2, '0);

		// Random: fill-to-full, drain-to-empty and mixed segments in turn
		n    = 0;
		kind = 0;
		while (n < RAND_WORDS) begin
			seg_len = $urandom_range(80, 140);
			case (kind % 3)
				0: push_pct = 85;
				1: push_pct = 15;
				default: push_pct = $urandom_range(30, 70);
			endcase
			focus = $urandom_range(0, NSTK - 1);
			for (int j = 0; j < seg_len && n < RAND_WORDS; j++) begin
				op  = ($urandom_range(1, 100) <= push_pct) ? REQ_PUSH : REQ_POP;
				sid = ($urandom_range(0, 1) == 0) ? focus : $urandom_range(0, NSTK - 1);
				add_op(op, sid, pick_value(), n == RAND_WORDS / 2,
					n == RAND_WORDS - CALM_WORDS);
				n++;
			end
			kind++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || req_ch.valid || expected_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(negedge clk);

		if (err_cnt == 0 && expected_rsp.size() == 0) begin
			$display("** shared_buffer_k_stacks: PASSED **");
		end else begin
			$display("** shared_buffer_k_stacks: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/skstk_pkg.sv
rtl/skstk_if.sv
rtl/skstk_slot_mem.sv
rtl/skstk_head_mem.sv
rtl/shared_buffer_k_stacks.sv
tb/tb_shared_buffer_k_stacks.sv
